// ----- design/sfd_pkg.sv -----
// Shared constants and control structs for the frame decoder.
package sfd_pkg;

  localparam int unsigned FRAME_BYTES  = 25;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CHAN_BITS    = 11;
  localparam int unsigned CBIT_W       = 4;
  localparam int unsigned CH_W         = 5;
  localparam int unsigned VAL_W        = 12;
  localparam int unsigned ANALOG_COUNT = 16;
  localparam int unsigned FLAG_BYTE    = 23;
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;

  localparam logic [BYTE_W-1:0]    SBUS_HEADER   = 8'h0F;
  localparam logic [BYTE_W-1:0]    SBUS_FOOTER   = 8'h00;
  localparam logic [BYTE_W-1:0]    PREV_RESET    = 8'hFF;
  localparam logic [CHAN_BITS-1:0] NEUTRAL_RESET = 11'd1024;
  localparam logic [CHAN_BITS-1:0] SPAN_RESET    = 11'd1024;

  // Register indexes (paddr[2])
  localparam logic REG_NEUTRAL = 1'b0;
  localparam logic REG_SPAN    = 1'b1;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
  } fb_ctrl_t;

  typedef struct packed {
    logic start;
    logic shift;
  } sub_ctrl_t;

endpackage

// ----- design/sfd_frame_buf.sv -----
// Frame store with byte position tracking and header/footer detection.
module sfd_frame_buf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sfd_pkg::fb_ctrl_t            ctrl_i,
  input  logic [sfd_pkg::BYTE_W-1:0]   wr_byte_i,
  output logic                         frame_hit_o,
  output logic [sfd_pkg::BYTE_W-1:0]   rd_data_o
);
  import sfd_pkg::*;

  logic [BYTE_W-1:0] mem_q [FRAME_BYTES];
  logic [BYTE_W-1:0] rd_data_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [BYTE_W-1:0] prev_q;

  always_comb begin
    if (wr_byte_i == SBUS_HEADER && prev_q == SBUS_FOOTER) begin
      pos_d = '0;
    end else if (pos_q >= POS_W'(FRAME_BYTES - 1)) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  assign frame_hit_o = (pos_d == POS_W'(FRAME_BYTES - 1)) && (wr_byte_i == SBUS_FOOTER);
  assign rd_data_o   = rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      prev_q <= PREV_RESET;
    end else if (ctrl_i.wr_en) begin
      pos_q  <= pos_d;
      prev_q <= wr_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[pos_d] <= wr_byte_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[ctrl_i.rd_addr];
    end
  end

endmodule

// ----- design/sfd_bit_sub.sv -----
// Bit-serial subtractor: channel bits in LSB first, minus the neutral value.
module sfd_bit_sub (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sfd_pkg::sub_ctrl_t              ctrl_i,
  input  logic                            bit_i,
  input  logic [sfd_pkg::CHAN_BITS-1:0]   neutral_i,
  output logic [sfd_pkg::VAL_W-1:0]       diff_o
);
  import sfd_pkg::*;

  logic [CHAN_BITS-1:0] nsr_q;
  logic [CHAN_BITS-1:0] res_q;
  logic                 borrow_q, borrow_d;
  logic                 diff_bit;

  assign diff_bit = bit_i ^ nsr_q[0] ^ borrow_q;
  assign borrow_d = (~bit_i & nsr_q[0]) | (~(bit_i ^ nsr_q[0]) & borrow_q);
  // Upper bit is the final borrow: sign of raw minus neutral
  assign diff_o   = {borrow_q, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      borrow_q <= 1'b0;
    end else if (ctrl_i.start) begin
      borrow_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      borrow_q <= borrow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      nsr_q <= neutral_i;
    end else if (ctrl_i.shift) begin
      nsr_q <= {1'b0, nsr_q[CHAN_BITS-1:1]};
      res_q <= {diff_bit, res_q[CHAN_BITS-1:1]};
    end
  end

endmodule

// ----- design/sbus_frame_decoder_core.sv -----
// Frame decoder top level: takes one received byte per request, and after a
// footer lands in the last frame position it emits sixteen centered analog
// channels and two digital flag channels. Bytes that do not complete a frame
// are taken one per cycle. A completing footer starts a decode, and no further
// byte is taken until it ends: channels are unpacked one bit per cycle
// through a bit-serial subtractor, each of the 23 frame store bytes is read
// from memory and then loaded, and each of the 18 results is emitted, waiting
// while the result side stalls.
module sbus_frame_decoder_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [sfd_pkg::BYTE_W-1:0]           rx_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sfd_pkg::CH_W-1:0]             channel_number_o,
  output logic signed [sfd_pkg::VAL_W-1:0]     channel_value_o,
  output logic                                 frame_end_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sfd_pkg::APB_AW-1:0]           paddr,
  input  logic [sfd_pkg::APB_DW-1:0]           pwdata,
  output logic [sfd_pkg::APB_DW-1:0]           prdata,
  output logic                                 pready
);
  import sfd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_FLAG  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [CHAN_BITS-1:0] neutral_q, span_q;
  logic [POS_W-1:0]     byte_idx_q, byte_idx_d;
  logic [2:0]           byte_bit_q, byte_bit_d;
  logic [CBIT_W-1:0]    chan_bit_q, chan_bit_d;
  logic [CH_W-1:0]      chan_q, chan_d;
  logic [BYTE_W-1:0]    byte_sr_q, byte_sr_d;

  logic                 out_valid_q, out_valid_d;
  logic [CH_W-1:0]      out_chan_q, out_chan_d;
  logic [VAL_W-1:0]     out_val_q, out_val_d;
  logic                 out_end_q, out_end_d;

  fb_ctrl_t             fb_ctrl;
  sub_ctrl_t            sub_ctrl;
  logic                 frame_hit;
  logic [BYTE_W-1:0]    rd_data;
  logic [VAL_W-1:0]     sub_diff;
  logic                 in_acc, out_free, cfg_wr, flag_bit;
  logic [VAL_W-1:0]     flag_val;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SPAN) ? APB_DW'(span_q) : APB_DW'(neutral_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q <= NEUTRAL_RESET;
      span_q    <= SPAN_RESET;
    end else if (cfg_wr && pready) begin
      if (paddr[2] == REG_NEUTRAL) begin
        neutral_q <= pwdata[CHAN_BITS-1:0];
      end else begin
        span_q <= pwdata[CHAN_BITS-1:0];
      end
    end
  end

  sfd_frame_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fb_ctrl),
    .wr_byte_i   (rx_byte_i),
    .frame_hit_o (frame_hit),
    .rd_data_o   (rd_data)
  );

  sfd_bit_sub u_sub (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (sub_ctrl),
    .bit_i     (byte_sr_q[0]),
    .neutral_i (neutral_q),
    .diff_o    (sub_diff)
  );

  // Bit 7 feeds channel 16, bit 6 feeds channel 17
  assign flag_bit = chan_q[0] ? byte_sr_q[6] : byte_sr_q[7];
  assign flag_val = flag_bit ? {1'b0, span_q} : (~{1'b0, span_q}) + VAL_W'(1);

  always_comb begin
    state_d     = state_q;
    byte_idx_d  = byte_idx_q;
    byte_bit_d  = byte_bit_q;
    chan_bit_d  = chan_bit_q;
    chan_d      = chan_q;
    byte_sr_d   = byte_sr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_chan_d  = out_chan_q;
    out_val_d   = out_val_q;
    out_end_d   = out_end_q;

    fb_ctrl.wr_en   = in_acc;
    fb_ctrl.rd_en   = 1'b0;
    fb_ctrl.rd_addr = byte_idx_q;
    sub_ctrl.start  = 1'b0;
    sub_ctrl.shift  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc && frame_hit) begin
          byte_idx_d     = POS_W'(1);
          byte_bit_d     = '0;
          chan_bit_d     = '0;
          chan_d         = '0;
          sub_ctrl.start = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        fb_ctrl.rd_en = 1'b1;
        state_d       = S_LOAD;
      end
      S_LOAD: begin
        byte_sr_d = rd_data;
        state_d   = (chan_q == CH_W'(ANALOG_COUNT)) ? S_FLAG : S_SHIFT;
      end
      S_SHIFT: begin
        sub_ctrl.shift = 1'b1;
        byte_sr_d      = {1'b0, byte_sr_q[BYTE_W-1:1]};
        byte_bit_d     = byte_bit_q + 3'd1;
        chan_bit_d     = (chan_bit_q == CBIT_W'(CHAN_BITS - 1)) ? '0
                                                                : chan_bit_q + CBIT_W'(1);
        if (byte_bit_q == 3'd7) begin
          byte_idx_d = byte_idx_q + POS_W'(1);
        end
        if (chan_bit_q == CBIT_W'(CHAN_BITS - 1)) begin
          state_d = S_EMIT;
        end else if (byte_bit_q == 3'd7) begin
          state_d = S_READ;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_chan_d     = chan_q;
          out_val_d      = sub_diff;
          out_end_d      = 1'b0;
          chan_d         = chan_q + CH_W'(1);
          sub_ctrl.start = 1'b1;
          // fetch the next byte once the current one is used up
          state_d        = (byte_bit_q == 3'd0) ? S_READ : S_SHIFT;
        end
      end
      S_FLAG: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_chan_d  = chan_q;
          out_val_d   = flag_val;
          out_end_d   = chan_q[0];
          chan_d      = chan_q + CH_W'(1);
          if (chan_q[0]) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      byte_idx_q  <= '0;
      byte_bit_q  <= '0;
      chan_bit_q  <= '0;
      chan_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      byte_idx_q  <= byte_idx_d;
      byte_bit_q  <= byte_bit_d;
      chan_bit_q  <= chan_bit_d;
      chan_q      <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_sr_q  <= byte_sr_d;
    out_chan_q <= out_chan_d;
    out_val_q  <= out_val_d;
    out_end_q  <= out_end_d;
  end

  assign out_valid_o      = out_valid_q;
  assign channel_number_o = out_chan_q;
  assign channel_value_o  = out_val_q;
  assign frame_end_o      = out_end_q;

endmodule

// ----- design/sfd_checker.sv -----
// Port-level checks for the frame decoder, bound to the top level.
module sfd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [sfd_pkg::CH_W-1:0]         channel_number_o,
  input logic signed [sfd_pkg::VAL_W-1:0] channel_value_o,
  input logic                             frame_end_o,
  input logic                             pready
);
  import sfd_pkg::*;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(ANALOG_COUNT + 1);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(channel_number_o)
      && $stable(channel_value_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_end_o == (channel_number_o == LAST_CH)))
    else $error("frame_end not on the last channel");

  a_busy_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> !in_ready_o)
    else $error("request taken while a frame is still decoding");

  a_next_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !frame_end_o ##1 out_valid_o
      |-> channel_number_o == $past(channel_number_o) + CH_W'(1))
    else $error("channel order broken");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind sbus_frame_decoder_core sfd_checker u_sfd_checker (.*);
